// File: sv/ibhq_pkg.sv
// ----------------------------------------------------------------------------
// ibhq_pkg
// Shared types and codes for the indexed binary heap queue.
// ----------------------------------------------------------------------------
package ibhq_pkg;

  localparam int TAG_W     = 6;
  localparam int TAG_COUNT = 64;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_REKEY  = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_IN_USE = 3'd4;

  typedef struct packed {
    logic [1:0]       action;
    logic [31:0]      entry_key;
    logic [TAG_W-1:0] entry_tag;
  } in_item_t;

  typedef struct packed {
    logic [31:0]      top_key;
    logic [TAG_W-1:0] top_tag;
    logic [TAG_W-1:0] removed_tag;
    logic [6:0]       entry_count;
    logic [2:0]       status;
  } out_item_t;

endpackage

// File: sv/ibhq_ram.sv
// ----------------------------------------------------------------------------
// ibhq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ibhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/indexed_binary_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_binary_heap_queue
// Binary heap priority queue with tag handles and in-place remove or rekey.
// ----------------------------------------------------------------------------
// Usage: each input transaction on in_valid/in_stall carries an action
// (insert, remove top, remove by tag, change key of tag), a key and a tag.
// Every input transaction produces exactly one output transaction on
// out_valid/out_stall with the root key and tag after the action, the tag
// taken out (if any), the entry count and a status code.
// The block works on one transaction at a time. The heap entries live in
// one RAM and the tag-to-position map in another, both with a registered
// read. After acceptance a transaction goes through lookup, placement and
// result read; taking an entry out adds a root read (pop only), a last
// entry read and a final down check; an upward sift reads and compares
// the parent per level climbed, and a downward sift reads the left child,
// reads the right child and compares per level. Removing the top of a
// full heap is the worst case. A new transaction is accepted only after
// the last one is through, and the heap RAM read port sets the pace.
// The result sits in an output register; the next input is accepted while
// it waits, and only the final result load waits for it. Reset clears the
// count, the tag valid bits, the mode register and the output valid; the
// RAM contents need no clearing. The user must write min_first through
// cfg_wr_en/cfg_wr_data only while the block idles; the block does not enforce it.
// ----------------------------------------------------------------------------
module indexed_binary_heap_queue
  import ibhq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int POS_W  = $clog2(CAPACITY + 1);
  localparam int HW     = KEY_BITS + TAG_W;
  localparam int KIN_W  = (KEY_BITS < 32) ? KEY_BITS : 32;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOOKUP = 4'd1;
  localparam logic [3:0] S_RM_T   = 4'd2;
  localparam logic [3:0] S_RM_X   = 4'd3;
  localparam logic [3:0] S_RM_L   = 4'd4;
  localparam logic [3:0] S_UP     = 4'd5;
  localparam logic [3:0] S_UP_C   = 4'd6;
  localparam logic [3:0] S_DOWN   = 4'd7;
  localparam logic [3:0] S_DN_L   = 4'd8;
  localparam logic [3:0] S_DN_R   = 4'd9;
  localparam logic [3:0] S_PLACE  = 4'd10;
  localparam logic [3:0] S_TOP    = 4'd11;
  localparam logic [3:0] S_TOPW   = 4'd12;

  // True when key a belongs above key b in the current order.
  function automatic logic better(input logic mf, input logic [KEY_BITS-1:0] a,
                                  input logic [KEY_BITS-1:0] b);
    better = mf ? (a < b) : (a > b);
  endfunction

  logic [3:0]          state_r, state_nxt;
  logic [1:0]          act_r, act_nxt;
  logic [KEY_BITS-1:0] cur_key_r, cur_key_nxt;
  logic [TAG_W-1:0]    cur_tag_r, cur_tag_nxt;
  logic [POS_W-1:0]    p_r, p_nxt;
  logic [POS_W-1:0]    cnt_r, cnt_nxt;
  logic                may_down_r, may_down_nxt;
  logic [TAG_W-1:0]    removed_r, removed_nxt;
  logic [2:0]          status_r, status_nxt;
  logic [KEY_BITS-1:0] lkey_r, lkey_nxt;
  logic [TAG_W-1:0]    ltag_r, ltag_nxt;
  logic                min_first_r;
  logic [TAG_COUNT-1:0] valid_r, valid_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Heap RAM holds {key, tag} at address position-1.
  logic              h_we;
  logic [ADDR_W-1:0] h_waddr, h_raddr;
  logic [HW-1:0]     h_wdata, h_rdata;
  logic [KEY_BITS-1:0] h_key;
  logic [TAG_W-1:0]    h_tag;

  // Tag map RAM holds the 1-based position of each tag; valid_r marks
  // entries that are present, so an unset entry reads as absent.
  logic              t_we;
  logic [TAG_W-1:0]  t_waddr, t_raddr;
  logic [POS_W-1:0]  t_wdata, t_rdata;

  logic [POS_W-1:0]  pos;
  logic              pos_ok;
  logic [POS_W:0]    left, right, cnt_x;
  logic              take_right;
  logic [KEY_BITS-1:0] b_key;
  logic [TAG_W-1:0]    b_tag;
  logic [POS_W-1:0]    b_pos;

  ibhq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  ibhq_ram #(.WIDTH(POS_W), .DEPTH(TAG_COUNT)) u_tag_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  assign h_key = h_rdata[HW-1:TAG_W];
  assign h_tag = h_rdata[TAG_W-1:0];

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign t_raddr   = in_data.entry_tag;

  assign pos    = valid_r[cur_tag_r] ? t_rdata : '0;
  assign pos_ok = (pos != '0) && (pos <= cnt_r);

  assign left  = {p_r, 1'b0};
  assign right = {p_r, 1'b1};
  assign cnt_x = {1'b0, cnt_r};

  // Child choice: the right child wins only when strictly better.
  assign take_right = (right <= cnt_x) && better(min_first_r, h_key, lkey_r);
  assign b_key = take_right ? h_key : lkey_r;
  assign b_tag = take_right ? h_tag : ltag_r;
  assign b_pos = take_right ? POS_W'(right) : POS_W'(left);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    cur_key_nxt   = cur_key_r;
    cur_tag_nxt   = cur_tag_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    may_down_nxt  = may_down_r;
    removed_nxt   = removed_r;
    status_nxt    = status_r;
    lkey_nxt      = lkey_r;
    ltag_nxt      = ltag_r;
    valid_nxt     = valid_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    h_we          = 1'b0;
    h_waddr       = ADDR_W'(p_r - POS_W'(1));
    h_wdata       = {cur_key_r, cur_tag_r};
    h_raddr       = '0;
    t_we          = 1'b0;
    t_waddr       = cur_tag_r;
    t_wdata       = p_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt     = in_data.action;
          cur_key_nxt = KEY_BITS'(in_data.entry_key[KIN_W-1:0]);
          cur_tag_nxt = in_data.entry_tag;
          status_nxt  = ST_OK;
          removed_nxt = '0;
          state_nxt   = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        unique case (act_r)
          ACT_INSERT: begin
            if (pos_ok) begin
              status_nxt = ST_IN_USE;
              state_nxt  = S_TOP;
            end else if (cnt_r >= POS_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_TOP;
            end else begin
              cnt_nxt      = cnt_r + POS_W'(1);
              p_nxt        = cnt_r + POS_W'(1);
              may_down_nxt = 1'b0;
              state_nxt    = S_UP;
            end
          end
          ACT_POP: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_TOP;
            end else begin
              p_nxt     = POS_W'(1);
              h_raddr   = '0;
              state_nxt = S_RM_T;
            end
          end
          ACT_REMOVE: begin
            if (!pos_ok) begin
              status_nxt = ST_ABSENT;
              state_nxt  = S_TOP;
            end else begin
              p_nxt       = pos;
              removed_nxt = cur_tag_r;
              state_nxt   = S_RM_X;
            end
          end
          default: begin
            if (!pos_ok) begin
              status_nxt = ST_ABSENT;
              state_nxt  = S_TOP;
            end else begin
              p_nxt        = pos;
              may_down_nxt = 1'b1;
              state_nxt    = S_UP;
            end
          end
        endcase
      end
      S_RM_T: begin
        removed_nxt = h_tag;
        state_nxt   = S_RM_X;
      end
      S_RM_X: begin
        valid_nxt[removed_r] = 1'b0;
        if (p_r == cnt_r) begin
          // The last entry goes away and nothing has to move.
          cnt_nxt   = cnt_r - POS_W'(1);
          state_nxt = S_TOP;
        end else begin
          h_raddr   = ADDR_W'(cnt_r - POS_W'(1));
          state_nxt = S_RM_L;
        end
      end
      S_RM_L: begin
        cur_key_nxt  = h_key;
        cur_tag_nxt  = h_tag;
        cnt_nxt      = cnt_r - POS_W'(1);
        may_down_nxt = 1'b1;
        state_nxt    = S_UP;
      end
      S_UP: begin
        if (p_r == POS_W'(1)) begin
          state_nxt = may_down_r ? S_DOWN : S_PLACE;
        end else begin
          h_raddr   = ADDR_W'((p_r >> 1) - POS_W'(1));
          state_nxt = S_UP_C;
        end
      end
      S_UP_C: begin
        if (better(min_first_r, cur_key_r, h_key)) begin
          // Parent moves down into the hole.
          h_we               = 1'b1;
          h_wdata            = h_rdata;
          t_we               = 1'b1;
          t_waddr            = h_tag;
          valid_nxt[h_tag]   = 1'b1;
          p_nxt              = p_r >> 1;
          may_down_nxt       = 1'b0;
          state_nxt          = S_UP;
        end else begin
          state_nxt = may_down_r ? S_DOWN : S_PLACE;
        end
      end
      S_DOWN: begin
        if (left > cnt_x) begin
          state_nxt = S_PLACE;
        end else begin
          h_raddr   = ADDR_W'(left - (POS_W + 1)'(1));
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        lkey_nxt  = h_key;
        ltag_nxt  = h_tag;
        h_raddr   = ADDR_W'(left);
        state_nxt = S_DN_R;
      end
      S_DN_R: begin
        if (better(min_first_r, b_key, cur_key_r)) begin
          // Best child moves up into the hole.
          h_we             = 1'b1;
          h_wdata          = {b_key, b_tag};
          t_we             = 1'b1;
          t_waddr          = b_tag;
          valid_nxt[b_tag] = 1'b1;
          p_nxt            = b_pos;
          state_nxt        = S_DOWN;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        h_we                 = 1'b1;
        t_we                 = 1'b1;
        valid_nxt[cur_tag_r] = 1'b1;
        state_nxt            = S_TOP;
      end
      S_TOP: begin
        h_raddr   = '0;
        state_nxt = S_TOPW;
      end
      S_TOPW: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.top_key     = (cnt_r != '0) ? 32'(h_key[KIN_W-1:0]) : '0;
          out_nxt.top_tag     = (cnt_r != '0) ? h_tag : '0;
          out_nxt.removed_tag = removed_r;
          out_nxt.entry_count = 7'(cnt_r);
          out_nxt.status      = status_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      valid_r     <= '0;
      min_first_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        min_first_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    cur_key_r  <= cur_key_nxt;
    cur_tag_r  <= cur_tag_nxt;
    p_r        <= p_nxt;
    may_down_r <= may_down_nxt;
    removed_r  <= removed_nxt;
    status_r   <= status_nxt;
    lkey_r     <= lkey_nxt;
    ltag_r     <= ltag_nxt;
    out_r      <= out_nxt;
  end

  // The count never goes past the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= POS_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // An accepted transaction always starts with the tag lookup.
  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_LOOKUP))
    else $error("accepted transaction did not start lookup");

  // Heap writes only land inside the occupied positions.
  a_heap_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    h_we |-> (POS_W'(h_waddr) < cnt_r))
    else $error("heap write outside occupied range");

  // A result is loaded only at the end of a transaction.
  a_result_from_topw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !(out_valid_r && out_stall)) |-> (state_r == S_TOPW))
    else $error("result loaded outside result state");

endmodule

// File: verif/indexed_binary_heap_queue_test.sv
// ----------------------------------------------------------------------------
// indexed_binary_heap_queue_test
// Self-checking bench for the tagged binary heap priority queue.
// ----------------------------------------------------------------------------
// The bench mirrors the heap in a small scoreboard class. It feeds a directed
// set of transactions, then random ones whose removes and rekeys mostly use tags
// known to be in the heap. Every output transaction is compared field by field
// with the oldest predicted result. Both directions idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module indexed_binary_heap_queue_test;
  import ibhq_pkg::*;

  localparam int CAPACITY = 64;
  localparam int CYCLE_LIMIT = 200000;

  // Scoreboard: keeps its own heap and the queue of predicted results.
  class heap_scoreboard;
    logic [31:0] keys[CAPACITY+1];
    logic [TAG_W-1:0] tags[CAPACITY+1];
    int tag_slot[TAG_COUNT];
    int held;
    bit min_first;
    out_item_t pending[$];
    int mismatches;

    function void clear_all();
      held = 0;
      min_first = 0;
      mismatches = 0;
      foreach (tag_slot[i]) tag_slot[i] = 0;
    endfunction

    function bit ranks_above(logic [31:0] a, logic [31:0] b);
      return min_first ? (a < b) : (a > b);
    endfunction

    function void swap_slots(int p, int q);
      logic [31:0] k;
      logic [TAG_W-1:0] t;
      k = keys[p]; t = tags[p];
      keys[p] = keys[q]; tags[p] = tags[q];
      keys[q] = k; tags[q] = t;
      tag_slot[tags[p]] = p;
      tag_slot[tags[q]] = q;
    endfunction

    function void climb(int p);
      while (p > 1 && ranks_above(keys[p], keys[p/2])) begin
        swap_slots(p/2, p);
        p = p / 2;
      end
    endfunction

    function void sink(int p);
      int pick;
      while (2 * p <= held) begin
        pick = 2 * p;
        if (pick + 1 <= held && ranks_above(keys[pick+1], keys[pick])) pick++;
        if (!ranks_above(keys[pick], keys[p])) break;
        swap_slots(p, pick);
        p = pick;
      end
    endfunction

    function void settle(int p);
      if (p > 1 && ranks_above(keys[p], keys[p/2])) climb(p);
      else sink(p);
    endfunction

    function void take_out(int p);
      tag_slot[tags[p]] = 0;
      if (p != held) begin
        keys[p] = keys[held];
        tags[p] = tags[held];
        tag_slot[tags[p]] = p;
      end
      held--;
      if (p <= held) settle(p);
    endfunction

    // Notes an accepted input transaction and queues its expected result.
    function void note_input(in_item_t it);
      out_item_t r;
      int pos;
      r = '0;
      pos = tag_slot[it.entry_tag];
      case (it.action)
        ACT_INSERT: begin
          if (pos != 0) r.status = ST_IN_USE;
          else if (held >= CAPACITY) r.status = ST_FULL;
          else begin
            held++;
            keys[held] = it.entry_key;
            tags[held] = it.entry_tag;
            tag_slot[it.entry_tag] = held;
            climb(held);
            r.status = ST_OK;
          end
        end
        ACT_POP: begin
          if (held == 0) r.status = ST_EMPTY;
          else begin
            r.removed_tag = tags[1];
            take_out(1);
            r.status = ST_OK;
          end
        end
        ACT_REMOVE: begin
          if (pos == 0) r.status = ST_ABSENT;
          else begin
            r.removed_tag = it.entry_tag;
            take_out(pos);
            r.status = ST_OK;
          end
        end
        default: begin
          if (pos == 0) r.status = ST_ABSENT;
          else begin
            keys[pos] = it.entry_key;
            settle(pos);
            r.status = ST_OK;
          end
        end
      endcase
      if (held != 0) begin
        r.top_key = keys[1];
        r.top_tag = tags[1];
      end
      r.entry_count = held[6:0];
      pending.push_back(r);
    endfunction

    // Checks one output transaction against the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.top_key !== want.top_key || got.top_tag !== want.top_tag ||
          got.removed_tag !== want.removed_tag ||
          got.entry_count !== want.entry_count || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_wr_en;
  logic cfg_wr_data;

  heap_scoreboard board;
  int cycle_count;
  bit calm_phase;  // When set, neither side idles or stalls.

  indexed_binary_heap_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // The cycle counter guards against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver stalls about one cycle in ten, except during the calm phase.
  // Results are sampled at the edge, before any nonblocking update lands.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    out_stall <= calm_phase ? 1'b0 : ($urandom_range(99) < 10);
  end

  // Sends one transaction: optional idle gap, then hold until accepted.
  // The scoreboard is told at the accepting edge, so order with results holds.
  task automatic send_item(in_item_t it);
    while (!calm_phase && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(it);
  endtask

  task automatic send_op(logic [1:0] op, logic [31:0] key, logic [TAG_W-1:0] tag);
    in_item_t it;
    it.action = op;
    it.entry_key = key;
    it.entry_tag = tag;
    send_item(it);
  endtask

  // Waits until every result has arrived, plus a margin for the sift.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Changes the ordering mode; only called while the block is idle.
  task automatic set_order(bit min_mode);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= min_mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.min_first = min_mode;
    @(posedge clk);
  endtask

  // Picks a tag that is currently held, or any tag when the heap is empty.
  function automatic logic [TAG_W-1:0] held_tag();
    if (board.held == 0) return TAG_W'($urandom_range(TAG_COUNT - 1));
    return board.tags[$urandom_range(board.held, 1)];
  endfunction

  function automatic logic [31:0] random_key();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(7);  // Small range forces many ties.
      default: return $urandom;
    endcase
  endfunction

  // One random transaction; removes and rekeys mostly use held tags.
  task automatic random_step();
    int pick;
    logic [TAG_W-1:0] tag;
    pick = $urandom_range(99);
    if (pick < 40) begin
      tag = TAG_W'($urandom_range(TAG_COUNT - 1));
      send_op(ACT_INSERT, random_key(), tag);
    end else if (pick < 55) begin
      send_op(ACT_POP, $urandom, TAG_W'($urandom_range(TAG_COUNT - 1)));
    end else if (pick < 72) begin
      tag = ($urandom_range(9) == 0) ? TAG_W'($urandom_range(TAG_COUNT - 1)) : held_tag();
      send_op(ACT_REMOVE, $urandom, tag);
    end else begin
      tag = ($urandom_range(9) == 0) ? TAG_W'($urandom_range(TAG_COUNT - 1)) : held_tag();
      send_op(ACT_REKEY, random_key(), tag);
    end
  endtask

  initial begin
    board = new();
    board.clear_all();
    cycle_count = 0;
    calm_phase = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: an empty pop, absent tags, duplicate tag, key extremes,
    // ties, rekey both ways, removal of the last array entry.
    send_op(ACT_POP, 32'h0, 6'd0);
    send_op(ACT_REMOVE, 32'h0, 6'd63);
    send_op(ACT_REKEY, 32'h0, 6'd5);
    send_op(ACT_INSERT, 32'hFFFF_FFFF, 6'd63);
    send_op(ACT_INSERT, 32'h0, 6'd0);
    send_op(ACT_INSERT, 32'h1234, 6'd63);
    send_op(ACT_INSERT, 32'h0, 6'd21);
    send_op(ACT_INSERT, 32'h0, 6'd42);
    send_op(ACT_REMOVE, 32'h0, 6'd42);
    send_op(ACT_REKEY, 32'hFFFF_FFFF, 6'd21);
    send_op(ACT_REKEY, 32'h0, 6'd21);
    send_op(ACT_REKEY, 32'h8000_0000, 6'd0);
    send_op(ACT_POP, 32'h0, 6'd0);
    send_op(ACT_REMOVE, 32'h0, 6'd63);
    send_op(ACT_POP, 32'h0, 6'd0);
    send_op(ACT_POP, 32'h0, 6'd0);
    // Fill to capacity, then one more insert with a held tag reports in use.
    for (int i = 0; i < CAPACITY; i++) send_op(ACT_INSERT, $urandom, i[TAG_W-1:0]);
    send_op(ACT_INSERT, 32'h5, 6'd10);
    drain();
    // A new tag is impossible when full, so free one slot and refill it.
    send_op(ACT_POP, 32'h0, 6'd0);
    send_op(ACT_INSERT, 32'h7, board.pending[$].removed_tag);
    drain();
    while (board.held != 0) send_op(ACT_POP, 32'h0, 6'd0);
    drain();

    // Random phases over both orderings; the third phase runs without idling.
    for (int phase = 0; phase < 4; phase++) begin
      set_order(phase[0]);
      calm_phase = (phase == 2);
      for (int n = 0; n < 65; n++) random_step();
      drain();
    end
    calm_phase = 0;
    set_order(1'b0);

    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
